>>> hw/rtl/fixed_point_alu_core_assert.svh
// Assertion macros for the fixed-point ALU core
`ifndef FIXED_POINT_ALU_CORE_ASSERT_SVH
`define FIXED_POINT_ALU_CORE_ASSERT_SVH
// implication under reset
`define FPA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication under reset
`define FPA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> hw/rtl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// Types and operation codes shared by the fixed-point ALU core.
// ----------------------------------------------------------------------------
package fpa_pkg;

    typedef enum logic [3:0] {
        OP_FROM_INT = 4'd0,
        OP_TO_INT   = 4'd1,
        OP_ADD      = 4'd2,
        OP_SUB      = 4'd3,
        OP_MUL      = 4'd4,
        OP_DIV      = 4'd5,
        OP_GT       = 4'd6,
        OP_LT       = 4'd7,
        OP_GE       = 4'd8,
        OP_LE       = 4'd9,
        OP_EQ       = 4'd10,
        OP_NE       = 4'd11,
        OP_MIN      = 4'd12,
        OP_MAX      = 4'd13,
        OP_INC      = 4'd14,
        OP_DEC      = 4'd15
    } op_kind_t;

    typedef struct packed {
        logic [3:0]         kind;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } fpa_in_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               compare_true;
        logic               overflow;
        logic               divide_by_zero;
    } fpa_out_t;

    localparam logic signed [31:0] MAX32 = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MIN32 = 32'sh8000_0000;

endpackage

>>> hw/rtl/fpa_div_cell.sv
// ----------------------------------------------------------------------------
// fpa_div_cell
// One restoring-division step: shifts in a numerator bit, trial subtract.
// ----------------------------------------------------------------------------
module fpa_div_cell import fpa_pkg::*; #(
    parameter int NW = 48,
    parameter int DW = 33
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          vld_in,
    input  logic [DW:0]   rem_in,
    input  logic [NW-1:0] num_in,
    input  logic [NW-1:0] quo_in,
    input  logic [DW-1:0] den_in,
    output logic          vld_out,
    output logic [DW:0]   rem_out,
    output logic [NW-1:0] num_out,
    output logic [NW-1:0] quo_out,
    output logic [DW-1:0] den_out
);

    logic [DW:0] shifted;
    logic [DW:0] diff;
    logic        ge;
    logic        vld_reg;
    logic [DW:0] rem_reg;
    logic [NW-1:0] num_reg;
    logic [NW-1:0] quo_reg;
    logic [DW-1:0] den_reg;

    always_comb
    begin
        shifted = {rem_in[DW-1:0], num_in[NW-1]};
        diff    = shifted - {1'b0, den_in};
        ge      = (shifted >= {1'b0, den_in});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= ge ? diff : shifted;
        num_reg <= {num_in[NW-2:0], 1'b0};
        quo_reg <= {quo_in[NW-2:0], ge};
        den_reg <= den_in;
    end

    assign vld_out = vld_reg;
    assign rem_out = rem_reg;
    assign num_out = num_reg;
    assign quo_out = quo_reg;
    assign den_out = den_reg;

endmodule

>>> hw/rtl/fixed_point_alu_core.sv
// ----------------------------------------------------------------------------
// fixed_point_alu_core
// Signed 32-bit fixed-point ALU, one beat per cycle, fixed latency.
// ----------------------------------------------------------------------------
// Every operation passes stages 0, 1, 2, the divider chain and the done register.
// Throughput: one beat per cycle; busy stays low.
// Depth is set by the divider chain: one cell per quotient bit (32+FRAC_BITS+1).
// Reset clears all valid bits; no results appear until new beats enter.
// The receiver cannot stall: done pulses for one cycle with each result.
module fixed_point_alu_core import fpa_pkg::*; #(
    parameter int FRAC_BITS = 8
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  fpa_in_t  in_data,
    output logic     done,
    output fpa_out_t out_data
);

    `include "fixed_point_alu_core_assert.svh"

    localparam int NW    = 32 + FRAC_BITS + 1;
    localparam int DW    = 33;
    localparam int STEPS = NW;

    // stage 0: register inputs, form magnitudes
    logic        s0_vld_reg;
    fpa_in_t     s0_reg;
    logic        acc;
    assign busy = 1'b0;
    assign acc  = start & ~busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
        end
        else
        begin
            s0_vld_reg <= acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s0_reg <= in_data;
        end
    end

    logic signed [32:0] a_ext;
    logic signed [32:0] b_ext;
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    assign a_ext = {s0_reg.operand_a[31], s0_reg.operand_a};
    assign b_ext = {s0_reg.operand_b[31], s0_reg.operand_b};
    assign mag_a = s0_reg.operand_a[31] ? 32'(-a_ext) : s0_reg.operand_a;
    assign mag_b = s0_reg.operand_b[31] ? 32'(-b_ext) : s0_reg.operand_b;

    // stage 1: non-divide result and the product
    logic        s1_vld_reg;
    logic [3:0]  s1_kind_reg;
    logic signed [31:0] s1_a_reg;
    logic        s1_neg_reg;
    logic        s1_bz_reg;
    logic [63:0] s1_prod_reg;
    logic [NW-1:0] s1_num_reg;
    logic [DW-1:0] s1_den_reg;
    fpa_out_t    s1_res_reg;
    fpa_out_t    simple;

    logic signed [33:0] sum;
    logic signed [33:0] dif;
    logic signed [33:0] incv;
    logic signed [33:0] decv;
    logic signed [63:0] fromv;
    logic               gt;

    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        if (v > 34'sd2147483647)
        begin
            return MAX32;
        end
        else if (v < -34'sd2147483648)
        begin
            return MIN32;
        end
        return v[31:0];
    endfunction

    always_comb
    begin
        sum   = 34'(a_ext) + 34'(b_ext);
        dif   = 34'(a_ext) - 34'(b_ext);
        incv  = 34'(a_ext) + 34'sd1;
        decv  = 34'(a_ext) - 34'sd1;
        fromv = 64'(s0_reg.operand_a) <<< FRAC_BITS;
        gt    = s0_reg.operand_a > s0_reg.operand_b;
        simple = '0;
        unique case (op_kind_t'(s0_reg.kind))
            OP_FROM_INT:
            begin
                if (fromv > 64'sd2147483647)
                begin
                    simple.result_value = MAX32;
                    simple.overflow     = 1'b1;
                end
                else if (fromv < -64'sd2147483648)
                begin
                    simple.result_value = MIN32;
                    simple.overflow     = 1'b1;
                end
                else
                begin
                    simple.result_value = fromv[31:0];
                end
            end
            OP_TO_INT: simple.result_value = s0_reg.operand_a >>> FRAC_BITS;
            OP_ADD:
            begin
                simple.result_value = sat34(sum);
                simple.overflow     = (sum[33:31] != {3{sum[33]}});
            end
            OP_SUB:
            begin
                simple.result_value = sat34(dif);
                simple.overflow     = (dif[33:31] != {3{dif[33]}});
            end
            OP_GT: simple.compare_true = gt;
            OP_LT: simple.compare_true = s0_reg.operand_a < s0_reg.operand_b;
            OP_GE: simple.compare_true = !(s0_reg.operand_a < s0_reg.operand_b);
            OP_LE: simple.compare_true = !gt;
            OP_EQ: simple.compare_true = s0_reg.operand_a == s0_reg.operand_b;
            OP_NE: simple.compare_true = s0_reg.operand_a != s0_reg.operand_b;
            OP_MIN: simple.result_value = gt ? s0_reg.operand_b : s0_reg.operand_a;
            OP_MAX: simple.result_value = gt ? s0_reg.operand_a : s0_reg.operand_b;
            OP_INC:
            begin
                simple.result_value = sat34(incv);
                simple.overflow     = (incv[33:31] != {3{incv[33]}});
            end
            OP_DEC:
            begin
                simple.result_value = sat34(decv);
                simple.overflow     = (decv[33:31] != {3{decv[33]}});
            end
            default: simple = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= s0_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_kind_reg <= s0_reg.kind;
        s1_a_reg    <= s0_reg.operand_a;
        s1_neg_reg  <= s0_reg.operand_a[31] ^ s0_reg.operand_b[31];
        s1_bz_reg   <= (s0_reg.operand_b == '0);
        s1_prod_reg <= 64'(mag_a) * 64'(mag_b);
        // numerator 2*|a|*2^F, denominator 2*|b|; +|b| rounding added later
        s1_num_reg  <= NW'({mag_a, 1'b0}) << FRAC_BITS;
        s1_den_reg  <= {mag_b, 1'b0};
        s1_res_reg  <= simple;
    end

    // stage 2: round product; prepare divider numerator with rounding term
    logic        s2_vld_reg;
    logic [3:0]  s2_kind_reg;
    logic signed [31:0] s2_a_reg;
    logic        s2_neg_reg;
    logic        s2_bz_reg;
    logic [63:0] s2_mq_reg;
    logic [NW-1:0] s2_num_reg;
    logic [DW-1:0] s2_den_reg;
    fpa_out_t    s2_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_kind_reg <= s1_kind_reg;
        s2_a_reg    <= s1_a_reg;
        s2_neg_reg  <= s1_neg_reg;
        s2_bz_reg   <= s1_bz_reg;
        s2_mq_reg   <= (s1_prod_reg + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        s2_num_reg  <= s1_num_reg + NW'(s1_den_reg[DW-1:1]);
        s2_den_reg  <= s1_den_reg;
        s2_res_reg  <= s1_res_reg;
    end

    // divider chain
    logic [STEPS:0]          c_vld;
    logic [STEPS:0][DW:0]    c_rem;
    logic [STEPS:0][NW-1:0]  c_num;
    logic [STEPS:0][NW-1:0]  c_quo;
    logic [STEPS:0][DW-1:0]  c_den;

    typedef struct packed {
        logic [3:0]         kind;
        logic signed [31:0] a;
        logic               neg;
        logic               bz;
        logic [63:0]        mq;
        fpa_out_t           res;
    } side_t;

    side_t side_reg [STEPS];
    side_t side_in;

    assign c_vld[0] = s2_vld_reg;
    assign c_rem[0] = '0;
    assign c_num[0] = s2_num_reg;
    assign c_quo[0] = '0;
    assign c_den[0] = s2_bz_reg ? DW'(1) : s2_den_reg;
    assign side_in  = '{kind: s2_kind_reg, a: s2_a_reg, neg: s2_neg_reg,
                        bz: s2_bz_reg, mq: s2_mq_reg, res: s2_res_reg};

    for (genvar i = 0; i < STEPS; i++)
    begin : g_cell
        fpa_div_cell #(.NW(NW), .DW(DW)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .vld_in  (c_vld[i]),
            .rem_in  (c_rem[i]),
            .num_in  (c_num[i]),
            .quo_in  (c_quo[i]),
            .den_in  (c_den[i]),
            .vld_out (c_vld[i+1]),
            .rem_out (c_rem[i+1]),
            .num_out (c_num[i+1]),
            .quo_out (c_quo[i+1]),
            .den_out (c_den[i+1])
        );
        always_ff @(posedge clk)
        begin
            side_reg[i] <= (i == 0) ? side_in : side_reg[(i == 0) ? 0 : i-1];
        end
    end

    // final stage: sign, saturate, select
    side_t       sd;
    logic [63:0] mag;
    logic        big;
    fpa_out_t    fin;
    logic        done_reg;
    fpa_out_t    out_reg;

    always_comb
    begin
        sd  = side_reg[STEPS-1];
        fin = sd.res;
        mag = (op_kind_t'(sd.kind) == OP_MUL) ? sd.mq : 64'(c_quo[STEPS]);
        big = sd.neg ? (mag > 64'h8000_0000) : (mag > 64'h7FFF_FFFF);
        if (op_kind_t'(sd.kind) == OP_DIV && sd.bz)
        begin
            fin = '0;
            fin.result_value   = sd.a[31] ? MIN32 : MAX32;
            fin.divide_by_zero = 1'b1;
        end
        else if (op_kind_t'(sd.kind) == OP_MUL || op_kind_t'(sd.kind) == OP_DIV)
        begin
            fin = '0;
            fin.overflow = big;
            if (big)
            begin
                fin.result_value = sd.neg ? MIN32 : MAX32;
            end
            else
            begin
                fin.result_value = sd.neg ? -mag[31:0] : mag[31:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= c_vld[STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= fin;
    end

    assign done     = done_reg;
    assign out_data = out_reg;

    `FPA_ASSERT_IMP(a_busy_low, 1'b1, !busy, "busy must stay low")
    `FPA_ASSERT_NXT(a_s0_follows, acc, s0_vld_reg, "accepted beat lost at entry")
    `FPA_ASSERT_IMP(a_flags_excl, done, !(out_data.overflow && out_data.divide_by_zero),
        "overflow and divide_by_zero together")
    `FPA_ASSERT_IMP(a_cmp_zero, done && out_data.compare_true, out_data.result_value == '0,
        "compare result carries nonzero value")

endmodule
